FILE: hdl/y4m_pkg.sv
// Shared types, constants and helper functions of the YUV4MPEG2 stream header parser.
// No dependencies; every other file of the block imports this package.
package y4m_pkg;

    localparam int HDR_BYTES = 128;
    localparam int POS_W     = $clog2(HDR_BYTES + 1);

    typedef enum logic [1:0] {
        PH_MAGIC = 2'd0,
        PH_LINE  = 2'd1,
        PH_FRAME = 2'd2,
        PH_FLINE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        TG_NONE = 3'd0,
        TG_W    = 3'd1,
        TG_H    = 3'd2,
        TG_I    = 3'd3,
        TG_FN   = 3'd4,
        TG_FD   = 3'd5,
        TG_C    = 3'd6
    } t_tag;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RAW   = 2'd1,
        ST_ERR   = 2'd2,
        ST_MIXED = 2'd3
    } t_status;

    localparam logic [1:0] SCAN_PROG = 2'd0;
    localparam logic [1:0] SCAN_TOP  = 2'd1;
    localparam logic [1:0] SCAN_BOT  = 2'd2;

    localparam logic [2:0] CH_420   = 3'd0;
    localparam logic [2:0] CH_444   = 3'd1;
    localparam logic [2:0] CH_422   = 3'd2;
    localparam logic [2:0] CH_411   = 3'd3;
    localparam logic [2:0] CH_444A  = 3'd4;
    localparam logic [2:0] CH_MONO  = 3'd5;

    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       first_byte;
        logic       file_end;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [31:0] rate_num;
        logic [31:0] rate_den;
        logic [1:0]  scan_order;
        logic [2:0]  chroma_code;
        logic [6:0]  frame_tag_pos;
        logic [7:0]  data_offset;
    } t_result;

    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "Y";
            4'd1:    c = "U";
            4'd2:    c = "V";
            4'd3:    c = "4";
            4'd4:    c = "M";
            4'd5:    c = "P";
            4'd6:    c = "E";
            4'd7:    c = "G";
            4'd8:    c = "2";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] frame_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "F";
            3'd1:    c = "R";
            3'd2:    c = "A";
            3'd3:    c = "M";
            3'd4:    c = "E";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] dec16(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, d};
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] dec32(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'h0, d};
        return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic token_end(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
               (b == 8'h0C) || (b == 8'h0D) || (b == 8'h00);
    endfunction

endpackage

FILE: hdl/y4m_in_stage.sv
// Input register of the header parser: holds one byte transaction for the parse core.
// Depends on y4m_pkg for the item type.
module y4m_in_stage
    import y4m_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_can_load,
    output logic     o_adv,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_adv   = r_valid && i_can_load;
    assign o_ready = !r_valid || i_can_load;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hdl/y4m_parse_core.sv
// Parse state and per-byte decode of the header parser: magic, tags, FRAME line.
// Depends on y4m_pkg for types, constants and decimal helpers.
module y4m_parse_core
    import y4m_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_in_item i_item,
    output logic     o_fire,
    output t_result  o_result
);

    logic [POS_W-1:0] r_pos;
    t_phase           r_phase;
    logic [7:0]       r_prev;
    t_tag             r_tag;
    logic [15:0]      r_w;
    logic [15:0]      r_h;
    logic [31:0]      r_num;
    logic [31:0]      r_den;
    logic [7:0]       r_chars [8];
    logic [3:0]       r_chroma_len;
    logic [2:0]       r_chroma;
    logic [1:0]       r_scan;
    logic [6:0]       r_tag_pos;
    logic             r_done;

    logic [POS_W-1:0] c_pos;
    t_phase           c_phase;
    logic [7:0]       c_prev;
    t_tag             c_tag;
    logic [15:0]      c_w;
    logic [15:0]      c_h;
    logic [31:0]      c_num;
    logic [31:0]      c_den;
    logic [7:0]       c_chars [8];
    logic [3:0]       c_chroma_len;
    logic [2:0]       c_chroma;
    logic [1:0]       c_scan;
    logic [6:0]       c_tag_pos;
    logic             c_done;

    t_phase           n_phase;
    t_tag             n_tag;
    logic [15:0]      n_w;
    logic [15:0]      n_h;
    logic [31:0]      n_num;
    logic [31:0]      n_den;
    logic [7:0]       n_chars [8];
    logic [3:0]       n_chroma_len;
    logic [2:0]       n_chroma;
    logic [1:0]       n_scan;
    logic [6:0]       n_tag_pos;

    logic [7:0]       b;
    logic             digit;
    logic [3:0]       dval;
    logic [POS_W-1:0] fidx;
    logic             nl_ok;
    logic             tag_ok;
    logic             fire;
    t_status          st;
    logic [7:0]       offset;

    assign b      = i_item.hdr_byte;
    assign digit  = (b >= "0") && (b <= "9");
    assign dval   = b[3:0];
    assign fidx   = c_pos - POS_W'(c_tag_pos);
    assign nl_ok  = (b == 8'h0A) && (32'(c_pos) + 32'd3 <= 32'(HDR_BYTES));
    assign tag_ok = (c_prev == 8'h20) && (32'(c_pos) >= 32'd10) &&
                    (32'(c_pos) + 32'd2 <= 32'(HDR_BYTES));

    // Restart view: a first byte sees the reset state.
    always_comb begin
        if (i_item.first_byte) begin
            c_pos        = '0;
            c_phase      = PH_MAGIC;
            c_prev       = 8'h00;
            c_tag        = TG_NONE;
            c_w          = '0;
            c_h          = '0;
            c_num        = '0;
            c_den        = '0;
            for (int k = 0; k < 8; k++) begin
                c_chars[k] = 8'h00;
            end
            c_chroma_len = '0;
            c_chroma     = CH_420;
            c_scan       = SCAN_PROG;
            c_tag_pos    = '0;
            c_done       = 1'b0;
        end else begin
            c_pos        = r_pos;
            c_phase      = r_phase;
            c_prev       = r_prev;
            c_tag        = r_tag;
            c_w          = r_w;
            c_h          = r_h;
            c_num        = r_num;
            c_den        = r_den;
            c_chars      = r_chars;
            c_chroma_len = r_chroma_len;
            c_chroma     = r_chroma;
            c_scan       = r_scan;
            c_tag_pos    = r_tag_pos;
            c_done       = r_done;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = c_phase;
        if (!c_done) begin
            unique case (c_phase)
                PH_MAGIC: begin
                    if (c_pos == POS_W'(8)) begin
                        n_phase = PH_LINE;
                    end
                end
                PH_LINE: begin
                    if (nl_ok) begin
                        n_phase = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (fidx == POS_W'(4)) begin
                        n_phase = PH_FLINE;
                    end
                end
                PH_FLINE: begin
                    n_phase = PH_FLINE;
                end
                default: begin
                    n_phase = c_phase;
                end
            endcase
        end
    end

    // Field updates and result.
    always_comb begin
        logic go_on;
        logic [2:0] ch_code;
        logic ch_hit;
        n_tag        = c_tag;
        n_w          = c_w;
        n_h          = c_h;
        n_num        = c_num;
        n_den        = c_den;
        n_chars      = c_chars;
        n_chroma_len = c_chroma_len;
        n_chroma     = c_chroma;
        n_scan       = c_scan;
        n_tag_pos    = c_tag_pos;
        fire         = 1'b0;
        st           = ST_OK;
        offset       = 8'h00;
        go_on        = 1'b1;
        ch_code      = CH_420;
        ch_hit       = 1'b1;

        if ({c_chars[0], c_chars[1], c_chars[2], c_chars[3],
             c_chars[4], c_chars[5], c_chars[6], c_chars[7]} == "444alpha") begin
            ch_code = CH_444A;
        end else if ({c_chars[0], c_chars[1], c_chars[2]} == "444") begin
            ch_code = CH_444;
        end else if ({c_chars[0], c_chars[1], c_chars[2]} == "422") begin
            ch_code = CH_422;
        end else if ({c_chars[0], c_chars[1], c_chars[2]} == "411") begin
            ch_code = CH_411;
        end else if ({c_chars[0], c_chars[1], c_chars[2]} == "420") begin
            ch_code = CH_420;
        end else if ({c_chars[0], c_chars[1], c_chars[2], c_chars[3]} == "mono") begin
            ch_code = CH_MONO;
        end else begin
            ch_hit = 1'b0;
        end

        if (!c_done) begin
            unique case (c_phase)
                PH_MAGIC: begin
                    if ((c_pos > POS_W'(8)) || (b != magic_char(c_pos[3:0]))) begin
                        fire = 1'b1;
                        st   = ST_RAW;
                    end
                end
                PH_LINE: begin
                    unique case (c_tag)
                        TG_I: begin
                            n_tag = TG_NONE;
                            if (b == "m") begin
                                fire  = 1'b1;
                                st    = ST_MIXED;
                                go_on = 1'b0;
                            end else if (b == "t") begin
                                n_scan = SCAN_TOP;
                            end else if (b == "b") begin
                                n_scan = SCAN_BOT;
                            end
                        end
                        TG_W: begin
                            if (digit) begin
                                n_w   = dec16(c_w, dval);
                                go_on = 1'b0;
                            end else begin
                                n_tag = TG_NONE;
                            end
                        end
                        TG_H: begin
                            if (digit) begin
                                n_h   = dec16(c_h, dval);
                                go_on = 1'b0;
                            end else begin
                                n_tag = TG_NONE;
                            end
                        end
                        TG_FN, TG_FD: begin
                            if (digit) begin
                                if (c_tag == TG_FN) begin
                                    n_num = dec32(c_num, dval);
                                end else begin
                                    n_den = dec32(c_den, dval);
                                end
                                go_on = 1'b0;
                            end else if ((c_tag == TG_FN) && (b == ":")) begin
                                n_tag = TG_FD;
                                go_on = 1'b0;
                            end else begin
                                n_tag = TG_NONE;
                                if ((c_num == 32'd0) || (c_den == 32'd0)) begin
                                    fire  = 1'b1;
                                    st    = ST_ERR;
                                    go_on = 1'b0;
                                end
                            end
                        end
                        TG_C: begin
                            if (!token_end(b)) begin
                                if (c_chroma_len < 4'd8) begin
                                    n_chars[c_chroma_len[2:0]] = b;
                                    n_chroma_len = c_chroma_len + 4'd1;
                                end
                                go_on = 1'b0;
                            end else begin
                                n_tag = TG_NONE;
                                if (ch_hit) begin
                                    n_chroma = ch_code;
                                end else begin
                                    fire  = 1'b1;
                                    st    = ST_ERR;
                                    go_on = 1'b0;
                                end
                            end
                        end
                        default: begin
                            n_tag = TG_NONE;
                        end
                    endcase

                    if (go_on) begin
                        if (nl_ok) begin
                            if ((c_num == 32'd0) || (c_den == 32'd0) ||
                                (c_w == 16'd0) || (c_h == 16'd0) ||
                                (32'(c_pos) + 32'd1 > 32'd127)) begin
                                fire = 1'b1;
                                st   = ST_ERR;
                            end else begin
                                n_tag_pos = 7'(32'(c_pos) + 32'd1);
                            end
                        end else if (tag_ok) begin
                            if (b == "W") begin
                                n_w   = '0;
                                n_tag = TG_W;
                            end else if (b == "H") begin
                                n_h   = '0;
                                n_tag = TG_H;
                            end else if (b == "I") begin
                                n_tag = TG_I;
                            end else if (b == "F") begin
                                n_num = '0;
                                n_den = '0;
                                n_tag = TG_FN;
                            end else if (b == "C") begin
                                for (int k = 0; k < 8; k++) begin
                                    n_chars[k] = 8'h00;
                                end
                                n_chroma_len = '0;
                                n_tag        = TG_C;
                            end
                        end
                    end
                end
                PH_FRAME: begin
                    if ((fidx >= POS_W'(5)) || (b != frame_char(fidx[2:0]))) begin
                        fire = 1'b1;
                        st   = ST_ERR;
                    end
                end
                PH_FLINE: begin
                    if (b == 8'h0A) begin
                        fire = 1'b1;
                        if (32'(c_pos) + 32'd1 > 32'd255) begin
                            st = ST_ERR;
                        end else begin
                            st     = ST_OK;
                            offset = 8'(32'(c_pos) + 32'd1);
                        end
                    end
                end
                default: begin
                    fire = 1'b0;
                end
            endcase

            if (!fire) begin
                if (i_item.file_end) begin
                    fire = 1'b1;
                    st   = (n_phase == PH_MAGIC) ? ST_RAW : ST_ERR;
                end else if (32'(c_pos) + 32'd1 >= 32'(HDR_BYTES)) begin
                    fire = 1'b1;
                    st   = ST_ERR;
                end
            end
        end
    end

    assign o_fire = fire;

    always_comb begin
        o_result        = '0;
        o_result.status = st;
        if (st == ST_OK) begin
            o_result.frame_width   = n_w;
            o_result.frame_height  = n_h;
            o_result.rate_num      = n_num;
            o_result.rate_den      = n_den;
            o_result.scan_order    = n_scan;
            o_result.chroma_code   = n_chroma;
            o_result.frame_tag_pos = n_tag_pos;
            o_result.data_offset   = offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= PH_MAGIC;
            r_prev       <= 8'h00;
            r_tag        <= TG_NONE;
            r_w          <= '0;
            r_h          <= '0;
            r_num        <= '0;
            r_den        <= '0;
            for (int k = 0; k < 8; k++) begin
                r_chars[k] <= 8'h00;
            end
            r_chroma_len <= '0;
            r_chroma     <= CH_420;
            r_scan       <= SCAN_PROG;
            r_tag_pos    <= '0;
            r_done       <= 1'b0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_tag        <= n_tag;
            r_w          <= n_w;
            r_h          <= n_h;
            r_num        <= n_num;
            r_den        <= n_den;
            r_chars      <= n_chars;
            r_chroma_len <= n_chroma_len;
            r_chroma     <= n_chroma;
            r_scan       <= n_scan;
            r_tag_pos    <= n_tag_pos;
            r_done       <= c_done || fire;
            if (!c_done) begin
                r_pos  <= c_pos + POS_W'(1);
                r_prev <= b;
            end else begin
                r_pos  <= c_pos;
                r_prev <= c_prev;
            end
        end
    end

`ifndef SYNTHESIS
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && i_adv && !i_item.first_byte) |-> !o_fire)
        else $error("second result without restart");

    a_chroma_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chroma_len <= 4'd8)
        else $error("chroma token length overrun");

    a_frame_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_done && (r_phase == PH_FRAME)) |-> ((r_pos - POS_W'(r_tag_pos)) < POS_W'(5)))
        else $error("FRAME marker index out of range");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(i_adv && i_item.first_byte)) |=> r_done)
        else $error("done flag dropped without restart");
`endif

endmodule

FILE: hdl/y4m_out_stage.sv
// Result register of the header parser: holds one result transaction until taken.
// Depends on y4m_pkg for the result type.
module y4m_out_stage
    import y4m_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_can_load
);

    logic    r_valid;
    t_result r_result;

    assign o_valid    = r_valid;
    assign o_result   = r_result;
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: hdl/y4m_stream_header_parser.sv
// YUV4MPEG2 stream header parser, top level: input register, parse core, result register.
// Depends on y4m_pkg, y4m_in_stage, y4m_parse_core and y4m_out_stage.
//
// Usage:
//   Feed the file start one byte per slave transaction: tdata holds the byte, tuser
//   marks the first byte of a file (parsing restarts at position zero), tlast marks
//   the final byte of the file. The block sends at most one master transaction per
//   file, once the outcome is known: tuser holds the status (ok, raw file, header
//   error, mixed interlace), tdata the parsed header fields and the FRAME position
//   and pixel data offset (all zero unless the status is ok). Bytes after the result
//   are dropped until the next first byte.
// Timing:
//   One byte per cycle while no result is held back by the receiver. A byte is held
//   in the input register, then decoded by the parse core into the result register.
//   The parse state loop is combinational between the state registers: decode, one
//   decimal multiply-add and the tag compare per byte.
// Reset and stall:
//   Synchronous reset clears the valid flags of both registers and the parse state; no clearing pass.
//   While a result waits for the receiver, one more byte can be accepted and held;
//   further bytes wait until the result is taken.
module y4m_stream_header_parser
    import y4m_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] hdr_byte
    input  logic         i_s_tuser,   // [0] first_byte
    input  logic         i_s_tlast,   // file_end
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [119:0] o_m_tdata,   // [15:0] frame_width, [31:16] frame_height,
                                      // [63:32] rate_num, [95:64] rate_den,
                                      // [97:96] scan_order, [100:98] chroma_code,
                                      // [107:101] frame_tag_pos, [115:108] data_offset
    output logic [1:0]   o_m_tuser    // [1:0] status
);

    t_in_item in_item;
    t_in_item core_item;
    t_result  core_result;
    t_result  out_result;
    logic     can_load;
    logic     adv;
    logic     fire;

    assign in_item.hdr_byte   = i_s_tdata;
    assign in_item.first_byte = i_s_tuser;
    assign in_item.file_end   = i_s_tlast;

    y4m_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_item     (in_item),
        .o_ready    (o_s_tready),
        .i_can_load (can_load),
        .o_adv      (adv),
        .o_item     (core_item)
    );

    y4m_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (core_item),
        .o_fire   (fire),
        .o_result (core_result)
    );

    y4m_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv && fire),
        .i_result   (core_result),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_result   (out_result),
        .o_can_load (can_load)
    );

    assign o_m_tuser = out_result.status;
    assign o_m_tdata = {4'h0,
                        out_result.data_offset,
                        out_result.frame_tag_pos,
                        out_result.chroma_code,
                        out_result.scan_order,
                        out_result.rate_den,
                        out_result.rate_num,
                        out_result.frame_height,
                        out_result.frame_width};

endmodule
